/* hw/rtl/crc_enc_pkg.sv */
// ----------------------------------------------------------------------------
// crc_enc_pkg
// Shared types and constants for the systematic CRC codeword encoder.
// ----------------------------------------------------------------------------
package crc_enc_pkg;

    localparam int MAX_GEN_LEN = 9;
    localparam int POLY_W      = 9;
    localparam int LEN_W       = 4;
    localparam int CW_W        = 24;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_POLY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd2;

    typedef struct packed {
        logic [POLY_W-1:0] poly;
        logic [LEN_W-1:0]  len;
        logic              mode8;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{poly: 9'd11, len: 4'd4, mode8: 1'b1};

    // codeword right aligned; three is set when it spans three bytes
    typedef struct packed {
        logic [CW_W-1:0] cw;
        logic            three;
    } t_word;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

endpackage

/* hw/rtl/crc_enc_front.sv */
// ----------------------------------------------------------------------------
// crc_enc_front
// Accepts input bytes, builds the codeword and hands it to the queue.
// ----------------------------------------------------------------------------
module crc_enc_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  crc_enc_pkg::t_cfg      i_cfg,
    input  logic                   i_push,
    input  logic [7:0]             i_data_byte,
    input  crc_enc_pkg::t_q_stat   i_q_stat,
    output logic                   o_full,
    output logic                   o_q_push,
    output crc_enc_pkg::t_word     o_word
);

    // remainder of a left-aligned dataword of nbits bits, one bit a step
    function automatic logic [7:0] f_rem(input logic [7:0] d, input logic [3:0] nbits,
                                         input logic [2:0] top, input logic [7:0] mask,
                                         input logic [7:0] gpl);
        logic [7:0] r;
        logic       fb;
        r = '0;
        for (int j = 0; j < 8; j++) begin
            if (4'(j) < nbits) begin
                fb = d[3'(7 - j)] ^ r[top];
                r  = ((r << 1) ^ (fb ? gpl : 8'd0)) & mask;
            end
        end
        return r;
    endfunction

    function automatic crc_enc_pkg::t_word f_encode(input logic [7:0] b,
                                                    input crc_enc_pkg::t_cfg c);
        logic [3:0]  len;
        logic [7:0]  mask;
        logic [7:0]  gpl;
        logic [7:0]  rem_b;
        logic [7:0]  rem_h;
        logic [7:0]  rem_l;
        logic [11:0] up;
        logic [11:0] lo;
        crc_enc_pkg::t_word w;
        if (c.len < 4'd2) begin
            len = 4'd2;
        end else if (c.len > 4'(crc_enc_pkg::MAX_GEN_LEN)) begin
            len = 4'(crc_enc_pkg::MAX_GEN_LEN);
        end else begin
            len = c.len;
        end
        mask  = 8'((9'd1 << (len - 4'd1)) - 9'd1);
        gpl   = c.poly[7:0] & mask;
        rem_b = f_rem(b, 4'd8, 3'(len - 4'd2), mask, gpl);
        rem_h = f_rem({b[7:4], 4'b0}, 4'd4, 3'(len - 4'd2), mask, gpl);
        rem_l = f_rem({b[3:0], 4'b0}, 4'd4, 3'(len - 4'd2), mask, gpl);
        up    = (12'({8'b0, b[7:4]}) << (len - 4'd1)) | {4'b0, rem_h};
        lo    = (12'({8'b0, b[3:0]}) << (len - 4'd1)) | {4'b0, rem_l};
        if (c.mode8) begin
            w.cw    = ({16'b0, b} << (len - 4'd1)) | {16'b0, rem_b};
            w.three = 1'b0;
        end else begin
            w.cw    = ({12'b0, up} << (len + 4'd3)) | {12'b0, lo};
            w.three = (len > 4'd5);
        end
        return w;
    endfunction

    logic               r_valid;
    logic               n_valid;
    crc_enc_pkg::t_word r_word;
    logic               accept;

    assign o_q_push = r_valid && !i_q_stat.full;
    assign o_full   = r_valid && i_q_stat.full;
    assign accept   = i_push && !o_full;
    assign o_word   = r_word;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= f_encode(i_data_byte, i_cfg);
        end
    end

endmodule

/* hw/rtl/crc_enc_queue.sv */
// ----------------------------------------------------------------------------
// crc_enc_queue
// Short queue of finished codewords between the front and the serializer.
// ----------------------------------------------------------------------------
module crc_enc_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  crc_enc_pkg::t_word     i_word,
    input  logic                   i_pop,
    output crc_enc_pkg::t_word     o_word,
    output crc_enc_pkg::t_q_stat   o_stat
);

    crc_enc_pkg::t_word                    r_mem [crc_enc_pkg::QUEUE_DEPTH];
    logic [crc_enc_pkg::QPTR_W-1:0]        r_wr_ptr;
    logic [crc_enc_pkg::QPTR_W-1:0]        r_rd_ptr;
    logic [crc_enc_pkg::QCNT_W-1:0]        r_count;
    logic [crc_enc_pkg::QCNT_W-1:0]        n_count;
    logic                                  do_push;
    logic                                  do_pop;

    assign o_stat.full  = (r_count == crc_enc_pkg::QCNT_W'(crc_enc_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;
    assign o_word       = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule

/* hw/rtl/crc_enc_back.sv */
// ----------------------------------------------------------------------------
// crc_enc_back
// Serializes queued codewords into bytes, most significant first.
// ----------------------------------------------------------------------------
module crc_enc_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  crc_enc_pkg::t_q_stat   i_q_stat,
    input  crc_enc_pkg::t_word     i_word,
    output logic                   o_q_pop,
    input  logic                   pop,
    output logic                   empty,
    output logic [7:0]             o_code_byte,
    output logic                   o_last_byte
);

    logic                          r_busy;
    logic [1:0]                    r_rem;
    logic [crc_enc_pkg::CW_W-1:0]  r_cw;
    logic                          r_out_valid;
    logic [7:0]                    r_out_byte;
    logic                          r_out_last;
    logic                          out_free;
    logic                          emit;
    logic                          is_last;
    logic [7:0]                    sel_byte;

    assign out_free = !r_out_valid || pop;
    assign emit     = r_busy && out_free;
    assign is_last  = (r_rem == 2'd1);
    // fetch a codeword while idle, or the next one as the current one sends its final byte
    assign o_q_pop  = !i_q_stat.empty && (!r_busy || (emit && is_last));

    always_comb begin
        case (r_rem)
            2'd3:    sel_byte = r_cw[23:16];
            2'd2:    sel_byte = r_cw[15:8];
            default: sel_byte = r_cw[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                if (is_last) begin
                    r_busy <= 1'b0;
                end
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
            if (o_q_pop) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= sel_byte;
            r_out_last <= is_last;
            r_rem      <= r_rem - 2'd1;
        end
        if (o_q_pop) begin
            r_cw  <= i_word.cw;
            r_rem <= i_word.three ? 2'd3 : 2'd2;
        end
    end

    assign empty       = !r_out_valid;
    assign o_code_byte = r_out_byte;
    assign o_last_byte = r_out_last;

endmodule

/* hw/rtl/crc_codeword_encoder_core.sv */
// ----------------------------------------------------------------------------
// crc_codeword_encoder_core
// Systematic CRC codeword encoder: byte in, 2 or 3 codeword bytes out.
//
//   channel   handshake             payload
//   input     push / full           i_data_byte
//   result    empty / pop           o_code_byte, o_last_byte
//   config    i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// A byte is taken every cycle while the codeword queue has room. Results
// leave one byte per cycle while pop is held, two or three per item; the
// serializer fetches the next item as the current one sends its final byte.
// First byte of an item passes front register, queue, serializer registers.
// Reset is synchronous, active low; it empties the pipeline and sets
// generator 11, length 4, 8-bit mode. Either side may stall independently.
// ----------------------------------------------------------------------------
module crc_codeword_encoder_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [7:0]                          i_data_byte,
    output logic                                empty,
    input  logic                                pop,
    output logic [7:0]                          o_code_byte,
    output logic                                o_last_byte,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [crc_enc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [crc_enc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    crc_enc_pkg::t_cfg     r_cfg;
    crc_enc_pkg::t_word    front_word;
    crc_enc_pkg::t_word    q_word;
    crc_enc_pkg::t_q_stat  q_stat;
    logic                  q_push;
    logic                  q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= crc_enc_pkg::CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                crc_enc_pkg::CFG_POLY: r_cfg.poly  <= i_cfg_data;
                crc_enc_pkg::CFG_LEN:  r_cfg.len   <= i_cfg_data[3:0];
                crc_enc_pkg::CFG_MODE: r_cfg.mode8 <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    crc_enc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_q_stat    (q_stat),
        .o_full      (full),
        .o_q_push    (q_push),
        .o_word      (front_word)
    );

    crc_enc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (front_word),
        .i_pop   (q_pop),
        .o_word  (q_word),
        .o_stat  (q_stat)
    );

    crc_enc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_word      (q_word),
        .o_q_pop     (q_pop),
        .pop         (pop),
        .empty       (empty),
        .o_code_byte (o_code_byte),
        .o_last_byte (o_last_byte)
    );

`ifndef SYNTH
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= crc_enc_pkg::QCNT_W'(crc_enc_pkg::QUEUE_DEPTH))
        else $error("codeword queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_stat.full))
        else $error("front pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("serializer popped an empty queue");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result side not empty after reset");
`endif

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for crc_codeword_encoder_core. A queue-fed driver pushes data
// bytes and performs register writes only when the encoder has drained. A
// monitor pops codeword bytes with random stalls and checks each one against
// bytes predicted from the current generator, length and mode settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TOTAL_BYTES    = 280;
    localparam int TIMEOUT_CYCLES = 400000;

    // index past the register list; writes to it must be dropped
    localparam logic [crc_enc_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;

    typedef enum logic [1:0] {
        JOB_BYTE,
        JOB_WRITE,
        JOB_DRAIN
    } t_job_kind;

    typedef struct {
        t_job_kind                          kind;
        logic [7:0]                         data;
        logic [crc_enc_pkg::CFG_IDX_W-1:0]  idx;
        logic [crc_enc_pkg::CFG_DATA_W-1:0] wdata;
    } t_enc_job;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } t_code_rec;

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               push        = 1'b0;
    logic                               full;
    logic [7:0]                         i_data_byte = '0;
    logic                               empty;
    logic                               pop         = 1'b0;
    logic [7:0]                         o_code_byte;
    logic                               o_last_byte;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [crc_enc_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [crc_enc_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    t_enc_job           enc_jobs[$];
    t_code_rec          code_bytes_exp[$];
    crc_enc_pkg::t_cfg  enc_cfg = crc_enc_pkg::CFG_RESET;
    int                 n_errors = 0;
    int                 n_bytes_queued = 0;
    logic               calm = 1'b0;
    int                 calm_left = 0;

    crc_codeword_encoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_data_byte (i_data_byte),
        .empty       (empty),
        .pop         (pop),
        .o_code_byte (o_code_byte),
        .o_last_byte (o_last_byte),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        n_errors++;
    endtask

    // mostly short gaps, a few long ones; none during a calm stretch
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [crc_enc_pkg::CW_W-1:0] crc_codeword(
        input logic [7:0] dword, input int dbits, input int glen,
        input logic [crc_enc_pkg::POLY_W-1:0] poly);
        logic [crc_enc_pkg::CW_W-1:0] gen;
        logic [crc_enc_pkg::CW_W-1:0] shifted;
        logic [crc_enc_pkg::CW_W-1:0] rem;
        int i;
        // bits at and above glen dropped, top bit forced high
        gen = crc_enc_pkg::CW_W'(poly)
            & ((crc_enc_pkg::CW_W'(1) << glen) - crc_enc_pkg::CW_W'(1));
        gen[glen-1] = 1'b1;
        shifted = crc_enc_pkg::CW_W'(dword) << (glen - 1);
        rem = shifted;
        for (i = dbits + glen - 2; i >= glen - 1; i--) begin
            if (rem[i])
                rem ^= gen << (i - glen + 1);
        end
        return shifted
             | (rem & ((crc_enc_pkg::CW_W'(1) << (glen - 1)) - crc_enc_pkg::CW_W'(1)));
    endfunction

    function automatic void predict_code_bytes(input logic [7:0] data);
        int glen;
        int cw_bits;
        int bits;
        int nbytes;
        int k;
        logic [crc_enc_pkg::CW_W-1:0] word;
        t_code_rec rec;
        glen = int'(enc_cfg.len);
        if (glen < 2)
            glen = 2;
        if (glen > crc_enc_pkg::MAX_GEN_LEN)
            glen = crc_enc_pkg::MAX_GEN_LEN;
        if (enc_cfg.mode8) begin
            word = crc_codeword(data, 8, glen, enc_cfg.poly);
            bits = 7 + glen;
        end else begin
            cw_bits = 3 + glen;
            word = (crc_codeword({4'h0, data[7:4]}, 4, glen, enc_cfg.poly) << cw_bits)
                 | crc_codeword({4'h0, data[3:0]}, 4, glen, enc_cfg.poly);
            bits = 2 * cw_bits;
        end
        nbytes = (bits + 7) / 8;
        for (k = 0; k < nbytes; k++) begin
            rec.code = 8'(word >> (8 * (nbytes - 1 - k)));
            rec.last = (k == nbytes - 1);
            code_bytes_exp = {code_bytes_exp, rec};
        end
    endfunction

    function automatic void add_byte(input logic [7:0] data);
        t_enc_job job;
        job.kind  = JOB_BYTE;
        job.data  = data;
        job.idx   = '0;
        job.wdata = '0;
        enc_jobs = {enc_jobs, job};
        n_bytes_queued++;
    endfunction

    function automatic void add_write(input logic [crc_enc_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [crc_enc_pkg::CFG_DATA_W-1:0] wdata);
        t_enc_job job;
        job.kind  = JOB_WRITE;
        job.data  = '0;
        job.idx   = idx;
        job.wdata = wdata;
        enc_jobs = {enc_jobs, job};
    endfunction

    function automatic void add_drain();
        t_enc_job job;
        job.kind  = JOB_DRAIN;
        job.data  = '0;
        job.idx   = '0;
        job.wdata = '0;
        enc_jobs = {enc_jobs, job};
    endfunction

    // alternate stretches with and without idling on both sides
    always @(posedge i_clk) begin
        if (calm_left == 0) begin
            calm      <= ($urandom_range(0, 2) == 0);
            calm_left <= $urandom_range(50, 200);
        end else begin
            calm_left <= calm_left - 1;
        end
    end

    // driver
    always @(posedge i_clk) begin : drive_proc
        logic push_n;
        logic cfg_n;
        t_enc_job job;
        int gap_left;
        int quiet;
        if (!i_rst_n) begin
            push        <= 1'b0;
            i_cfg_valid <= 1'b0;
            i_data_byte <= '0;
            i_cfg_index <= '0;
            i_cfg_data  <= '0;
            enc_cfg     = crc_enc_pkg::CFG_RESET;
            gap_left    = 0;
            quiet       = 0;
        end else begin
            push_n = push;
            cfg_n  = i_cfg_valid;
            if (push && !full) begin
                predict_code_bytes(i_data_byte);
                push_n = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    crc_enc_pkg::CFG_POLY:
                        enc_cfg.poly  = i_cfg_data[crc_enc_pkg::POLY_W-1:0];
                    crc_enc_pkg::CFG_LEN:
                        enc_cfg.len   = i_cfg_data[crc_enc_pkg::LEN_W-1:0];
                    crc_enc_pkg::CFG_MODE:
                        enc_cfg.mode8 = i_cfg_data[0];
                    default:  ;
                endcase
                cfg_n = 1'b0;
            end
            quiet = (code_bytes_exp.size() == 0) ? quiet + 1 : 0;
            if (!push_n && !cfg_n && enc_jobs.size() != 0) begin
                job = enc_jobs[0];
                if (job.kind == JOB_BYTE) begin
                    if (gap_left != 0) begin
                        gap_left--;
                    end else begin
                        push_n = 1'b1;
                        i_data_byte <= job.data;
                        void'(enc_jobs.pop_front());
                        gap_left = pick_gap();
                    end
                end else if (quiet >= SETTLE_CYCLES) begin
                    // writes and drain points wait until the encoder is empty
                    if (job.kind == JOB_WRITE) begin
                        cfg_n = 1'b1;
                        i_cfg_index <= job.idx;
                        i_cfg_data  <= job.wdata;
                    end
                    void'(enc_jobs.pop_front());
                end
            end
            push        <= push_n;
            i_cfg_valid <= cfg_n;
        end
    end

    // monitor
    always @(posedge i_clk) begin : check_proc
        t_code_rec want;
        int stall_left;
        if (!i_rst_n) begin
            pop <= 1'b0;
            stall_left = 0;
        end else begin
            if (pop && !empty) begin
                if (code_bytes_exp.size() == 0) begin
                    report_mismatch($sformatf("unexpected code byte %02h last %0b",
                                              o_code_byte, o_last_byte));
                end else begin
                    want = code_bytes_exp.pop_front();
                    if (o_code_byte !== want.code)
                        report_mismatch($sformatf("code_byte %02h, want %02h",
                                                  o_code_byte, want.code));
                    if (o_last_byte !== want.last)
                        report_mismatch($sformatf("last_byte %0b, want %0b",
                                                  o_last_byte, want.last));
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("FAIL");
        $finish;
    end

    initial begin : main_proc
        int n;
        int i;
        // reset settings: generator 1011, 8-bit words
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h80);
        add_byte(8'h01);
        add_byte(8'h55);
        add_byte(8'hAA);
        add_write(crc_enc_pkg::CFG_MODE, 9'd0);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'hF0);
        add_byte(8'h0F);
        // length under range acts as 2
        add_write(crc_enc_pkg::CFG_LEN, 9'd0);
        add_byte(8'hA5);
        add_write(crc_enc_pkg::CFG_LEN, 9'd1);
        add_byte(8'h5A);
        // length over range acts as 9; nibble mode gives three bytes
        add_write(crc_enc_pkg::CFG_POLY, 9'h1FF);
        add_write(crc_enc_pkg::CFG_LEN, 9'd15);
        add_byte(8'hFF);
        add_byte(8'h3C);
        add_write(crc_enc_pkg::CFG_MODE, 9'd1);
        add_byte(8'hC3);
        // top generator bit clear, junk above it
        add_write(crc_enc_pkg::CFG_LEN, 9'd6);
        add_write(crc_enc_pkg::CFG_POLY, 9'h1C3);
        add_byte(8'h7E);
        add_byte(8'h81);
        // write to a missing register is dropped
        add_write(CFG_NONE, 9'h1FF);
        add_byte(8'h96);
        add_drain();
        add_write(crc_enc_pkg::CFG_POLY, 9'd0);
        add_write(crc_enc_pkg::CFG_LEN, 9'd2);
        add_byte(8'hE7);

        while (n_bytes_queued < TOTAL_BYTES) begin
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 3))
                    0:       add_write(crc_enc_pkg::CFG_POLY, 9'd0);
                    1:       add_write(crc_enc_pkg::CFG_POLY, 9'h1FF);
                    default: add_write(crc_enc_pkg::CFG_POLY, 9'($urandom_range(0, 511)));
                endcase
            end
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 3))
                    0:       add_write(crc_enc_pkg::CFG_LEN, 9'd2);
                    1:       add_write(crc_enc_pkg::CFG_LEN, 9'd9);
                    default: add_write(crc_enc_pkg::CFG_LEN, 9'($urandom_range(0, 15)));
                endcase
            end
            if ($urandom_range(0, 1) == 0)
                add_write(crc_enc_pkg::CFG_MODE, 9'($urandom_range(0, 511)));
            if ($urandom_range(0, 5) == 0)
                add_write(CFG_NONE, 9'($urandom_range(0, 511)));
            n = $urandom_range(10, 40);
            for (i = 0; i < n && n_bytes_queued < TOTAL_BYTES; i++) begin
                add_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 59) == 0)
                    add_drain();
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (enc_jobs.size() != 0 || push || i_cfg_valid || code_bytes_exp.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
